FILE: design/dkit_pkg.sv
// ----------------------------------------------------------------------------
// dkit_pkg
// Shared types, constants and helper functions for the decimal key index
// table: beat formats, command codes and radix power functions.
// ----------------------------------------------------------------------------
package dkit_pkg;

   localparam int KEY_W      = 14;
   localparam int ADDR_W     = 32;
   localparam int RANK_W     = 4;
   localparam int NODE_W     = 11;
   localparam int MAX_DIGITS = 6;

   localparam int KEY_DIGITS_DEF = 4;
   localparam int RADIX_DEF      = 10;

   localparam logic [NODE_W-1:0] NODE_MAX = '1;
   localparam logic [RANK_W-1:0] RANK_MAX = '1;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] record_addr;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [RANK_W-1:0] rank;
      logic [ADDR_W-1:0] addr_out;
      logic [NODE_W-1:0] node_count;
   } rsp_type;

   typedef struct packed {
      logic present_we;
      logic prefix_we;
      logic prefix_set;
      logic leaf_addr_we;
   } tbl_ctl_type;

   function automatic int unsigned radix_pow(input int unsigned r, input int unsigned n);
      int unsigned v;
      v = 1;
      for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
         if (i < n) begin
            v = v * r;
         end
      end
      return v;
   endfunction

   // first slot of the prefixes of a given length
   function automatic int unsigned prefix_base(input int unsigned r, input int unsigned len);
      int unsigned v;
      int unsigned p;
      v = 0;
      p = 1;
      for (int unsigned i = 1; i < MAX_DIGITS; i++) begin
         if (i < len) begin
            p = p * r;
            v = v + p;
         end
      end
      return v;
   endfunction

endpackage

FILE: design/dkit_divider.sv
// ----------------------------------------------------------------------------
// dkit_divider
// Shared constant divider: quotient by reciprocal multiplication, remainder
// by multiply-back and subtract. Divides by key space or radix, registering
// quotient, then remainder, then done; results held until the next start.
// ----------------------------------------------------------------------------
module dkit_divider
   import dkit_pkg::*;
#(
   parameter int RADIX    = RADIX_DEF,
   parameter int KEYSPACE = int'(radix_pow(RADIX_DEF, KEY_DIGITS_DEF))
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             by_keyspace,
   input  logic [KEY_W-1:0] dividend,
   output logic             done,
   output logic [KEY_W-1:0] quotient,
   output logic [KEY_W-1:0] remainder
);

   localparam int MUL_W  = KEY_W + 2;
   localparam int PROD_W = KEY_W + MUL_W;
   localparam int SH_K   = KEY_W + $clog2(KEYSPACE);
   localparam int SH_R   = KEY_W + $clog2(RADIX);

   localparam logic [MUL_W-1:0] MUL_K =
      MUL_W'(((64'd1 << SH_K) + 64'(KEYSPACE) - 64'd1) / 64'(KEYSPACE));
   localparam logic [MUL_W-1:0] MUL_R =
      MUL_W'(((64'd1 << SH_R) + 64'(RADIX) - 64'd1) / 64'(RADIX));
   localparam logic [KEY_W-1:0] DLO_K = KEY_W'(KEYSPACE);
   localparam logic [KEY_W-1:0] DLO_R = KEY_W'(RADIX);

   logic [KEY_W-1:0]   x_ff;
   logic               sel_ff;
   logic               calc_ff;
   logic               fix_ff;
   logic               done_ff;
   logic [KEY_W-1:0]   quo_ff, quo_in;
   logic [KEY_W-1:0]   rem_ff, rem_in;
   logic [MUL_W-1:0]   mul_c;
   logic [KEY_W-1:0]   dlo;
   logic [PROD_W-1:0]  prod;
   logic [2*KEY_W-1:0] back;

   always_comb begin
      mul_c  = sel_ff ? MUL_K : MUL_R;
      dlo    = sel_ff ? DLO_K : DLO_R;
      prod   = x_ff * mul_c;
      quo_in = sel_ff ? KEY_W'(prod >> SH_K) : KEY_W'(prod >> SH_R);
      back   = quo_ff * dlo;
      rem_in = x_ff - back[KEY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calc_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         calc_ff <= start;
         fix_ff  <= calc_ff;
         done_ff <= fix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= dividend;
         sel_ff <= by_keyspace;
      end
      if (calc_ff) begin
         quo_ff <= quo_in;
      end
      if (fix_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/dkit_tables.sv
// ----------------------------------------------------------------------------
// dkit_tables
// Storage of the index: presence mask per leaf group, prefix seen flags and
// record address per key. Single address per store, registered read.
// ----------------------------------------------------------------------------
module dkit_tables
   import dkit_pkg::*;
#(
   parameter int RADIX        = RADIX_DEF,
   parameter int LEAF_GROUPS  = 1000,
   parameter int PREFIX_SLOTS = 1110,
   parameter int KEYSPACE     = 10000
) (
   input  logic                            clock,
   input  tbl_ctl_type                     ctl,
   input  logic [$clog2(LEAF_GROUPS)-1:0]  present_addr,
   input  logic [RADIX-1:0]                present_wdata,
   output logic [RADIX-1:0]                present_rdata,
   input  logic [$clog2(PREFIX_SLOTS)-1:0] prefix_addr,
   output logic                            prefix_rdata,
   input  logic [$clog2(KEYSPACE)-1:0]     leaf_addr,
   input  logic [ADDR_W-1:0]               leaf_wdata,
   output logic [ADDR_W-1:0]               leaf_rdata
);

   logic [RADIX-1:0]  present_mem [LEAF_GROUPS];
   logic              prefix_mem  [PREFIX_SLOTS];
   logic [ADDR_W-1:0] leaf_mem    [KEYSPACE];

   logic [RADIX-1:0]  present_rd_ff;
   logic              prefix_rd_ff;
   logic [ADDR_W-1:0] leaf_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.present_we) begin
         present_mem[present_addr] <= present_wdata;
      end
      present_rd_ff <= present_mem[present_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.prefix_we) begin
         prefix_mem[prefix_addr] <= ctl.prefix_set;
      end
      prefix_rd_ff <= prefix_mem[prefix_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.leaf_addr_we) begin
         leaf_mem[leaf_addr] <= leaf_wdata;
      end
      leaf_rd_ff <= leaf_mem[leaf_addr];
   end

   assign present_rdata = present_rd_ff;
   assign prefix_rdata  = prefix_rd_ff;
   assign leaf_rdata    = leaf_rd_ff;

endmodule

FILE: design/decimal_key_index_table.sv
// ----------------------------------------------------------------------------
// decimal_key_index_table
// Index over fixed-length keys in base RADIX, kept as a radix trie: inserts
// store a record address and count trie nodes, lookups report presence,
// address and rank among siblings.
//
// Request channel (req_valid/req_ready/req_data) takes one beat per command;
// each beat gives exactly one beat on the response channel
// (rsp_valid/rsp_ready/rsp_data). One command is in work at a time.
// Work is done by one shared constant divider: one division to reduce the
// key into the key space, then one per digit split. A lookup takes 2
// divisions; an insert takes KEY_DIGITS divisions and a prefix check after
// each digit split, then both read and update the leaf group.
// After reset the presence and prefix stores are swept to zero, one entry a
// cycle across all PREFIX_SLOTS prefix entries; req_ready stays low
// meanwhile and node_count restarts at 1.
// The response is held in an output register: a stalled receiver holds the
// beat, and a further command is taken but its result waits for the slot.
// ----------------------------------------------------------------------------
module decimal_key_index_table
   import dkit_pkg::*;
#(
   parameter int KEY_DIGITS = KEY_DIGITS_DEF,
   parameter int RADIX      = RADIX_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int KEYSPACE     = int'(radix_pow(RADIX, KEY_DIGITS));
   localparam int LEAF_GROUPS  = int'(radix_pow(RADIX, KEY_DIGITS - 1));
   localparam int PREFIX_SLOTS = (RADIX * (LEAF_GROUPS - 1)) / (RADIX - 1);
   localparam int GRP_W        = $clog2(LEAF_GROUPS);
   localparam int PRE_W        = $clog2(PREFIX_SLOTS);
   localparam int KADDR_W      = $clog2(KEYSPACE);
   localparam int DIG_W        = $clog2(RADIX);
   localparam int PH_W         = $clog2(KEY_DIGITS);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_DIV      = 3'd2;
   localparam logic [2:0] ST_PRE_RD   = 3'd3;
   localparam logic [2:0] ST_PRE_CHK  = 3'd4;
   localparam logic [2:0] ST_LEAF_RD  = 3'd5;
   localparam logic [2:0] ST_LEAF_UPD = 3'd6;
   localparam logic [2:0] ST_OUT      = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [PRE_W-1:0]   clr_ff, clr_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic               cmd_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [KADDR_W-1:0] k_ff, k_in;
   logic [GRP_W-1:0]   grp_ff, grp_in;
   logic [DIG_W-1:0]   dig_ff, dig_in;
   logic [PRE_W-1:0]   pre_idx_ff, pre_idx_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               div_start;
   logic               div_by_keyspace;
   logic [KEY_W-1:0]   div_dividend;
   logic               div_done;
   logic [KEY_W-1:0]   div_quo;
   logic [KEY_W-1:0]   div_rem;

   tbl_ctl_type        ctl;
   logic [GRP_W-1:0]   present_addr;
   logic [RADIX-1:0]   present_wdata;
   logic [RADIX-1:0]   present_rd;
   logic [PRE_W-1:0]   prefix_addr;
   logic               prefix_rd;
   logic [ADDR_W-1:0]  leaf_rd;

   logic [RADIX-1:0]   dig_bit;
   logic [RADIX-1:0]   below;
   logic [RANK_W:0]    pop;
   logic [RANK_W:0]    rank_sum;
   logic [RANK_W-1:0]  rank_sat;
   logic               req_fire;
   logic               out_free;

   dkit_divider #(
      .RADIX   (RADIX),
      .KEYSPACE(KEYSPACE)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .by_keyspace(div_by_keyspace),
      .dividend   (div_dividend),
      .done       (div_done),
      .quotient   (div_quo),
      .remainder  (div_rem)
   );

   dkit_tables #(
      .RADIX       (RADIX),
      .LEAF_GROUPS (LEAF_GROUPS),
      .PREFIX_SLOTS(PREFIX_SLOTS),
      .KEYSPACE    (KEYSPACE)
   ) u_tables (
      .clock        (clock),
      .ctl          (ctl),
      .present_addr (present_addr),
      .present_wdata(present_wdata),
      .present_rdata(present_rd),
      .prefix_addr  (prefix_addr),
      .prefix_rdata (prefix_rd),
      .leaf_addr    (k_ff),
      .leaf_wdata   (addr_ff),
      .leaf_rdata   (leaf_rd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // rank and set mask of the current leaf group
   always_comb begin
      pop = '0;
      for (int i = 0; i < RADIX; i++) begin
         dig_bit[i] = (i == int'(dig_ff));
         below[i]   = present_rd[i] && (i < int'(dig_ff));
         pop        = pop + (RANK_W + 1)'(below[i]);
      end
      rank_sum = pop + (RANK_W + 1)'(1);
      rank_sat = (rank_sum > (RANK_W + 1)'(RANK_MAX)) ? RANK_MAX : rank_sum[RANK_W-1:0];
   end

   always_comb begin
      present_addr  = (state_ff == ST_CLEAR) ? GRP_W'(clr_ff) : grp_ff;
      prefix_addr   = (state_ff == ST_CLEAR) ? clr_ff : pre_idx_ff;
      present_wdata = (state_ff == ST_CLEAR) ? '0 : (present_rd | dig_bit);
   end

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      node_in         = node_ff;
      phase_in        = phase_ff;
      k_in            = k_ff;
      grp_in          = grp_ff;
      dig_in          = dig_ff;
      pre_idx_in      = pre_idx_ff;
      res_in          = res_ff;
      div_start       = 1'b0;
      div_dividend    = req_data.key;
      div_by_keyspace = 1'b1;
      ctl             = '0;
      ctl.prefix_set  = (state_ff != ST_CLEAR);

      case (state_ff)
         ST_CLEAR: begin
            ctl.prefix_we  = 1'b1;
            ctl.present_we = ({1'b0, clr_ff} < (PRE_W + 1)'(LEAF_GROUPS));
            clr_in         = clr_ff + PRE_W'(1);
            if (clr_ff == PRE_W'(PREFIX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               div_start = 1'b1;
               phase_in  = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (phase_ff == '0) begin
                  k_in            = KADDR_W'(div_rem);
                  div_start       = 1'b1;
                  div_dividend    = div_rem;
                  div_by_keyspace = 1'b0;
                  phase_in        = PH_W'(1);
               end else begin
                  if (phase_ff == PH_W'(1)) begin
                     grp_in = GRP_W'(div_quo);
                     dig_in = DIG_W'(div_rem);
                  end
                  pre_idx_in = PRE_W'(prefix_base(RADIX, KEY_DIGITS - int'(phase_ff)))
                             + PRE_W'(div_quo);
                  state_in   = (cmd_ff == CMD_LOOKUP) ? ST_LEAF_RD : ST_PRE_RD;
               end
            end
         end
         ST_PRE_RD: begin
            state_in = ST_PRE_CHK;
         end
         ST_PRE_CHK: begin
            if (!prefix_rd) begin
               ctl.prefix_we = 1'b1;
               if (node_ff != NODE_MAX) begin
                  node_in = node_ff + NODE_W'(1);
               end
            end
            if (phase_ff == PH_W'(KEY_DIGITS - 1)) begin
               state_in = ST_LEAF_RD;
            end else begin
               div_start       = 1'b1;
               div_dividend    = div_quo;
               div_by_keyspace = 1'b0;
               phase_in        = phase_ff + PH_W'(1);
               state_in        = ST_DIV;
            end
         end
         ST_LEAF_RD: begin
            state_in = ST_LEAF_UPD;
         end
         ST_LEAF_UPD: begin
            res_in.node_count = node_ff;
            if (cmd_ff == CMD_INSERT) begin
               ctl.present_we   = 1'b1;
               ctl.leaf_addr_we = 1'b1;
               res_in.found     = 1'b1;
               res_in.rank      = rank_sat;
               res_in.addr_out  = addr_ff;
            end else if (present_rd[dig_ff]) begin
               res_in.found    = 1'b1;
               res_in.rank     = rank_sat;
               res_in.addr_out = leaf_rd;
            end else begin
               res_in.found    = 1'b0;
               res_in.rank     = '0;
               res_in.addr_out = '0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         node_ff      <= NODE_W'(1);
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         node_ff  <= node_in;
         phase_ff <= phase_in;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_data.cmd;
         addr_ff <= req_data.record_addr;
      end
      k_ff       <= k_in;
      grp_ff     <= grp_in;
      dig_ff     <= dig_in;
      pre_idx_ff <= pre_idx_in;
      res_ff     <= res_in;
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/tb_decimal_key_index_table.sv
// ----------------------------------------------------------------------------
// tb_decimal_key_index_table
// Self-checking bench for the decimal key index table. After directed beats,
// insert and lookup beats go in through the request channel in random bursts
// while the response channel stalls on a shifting pattern, with one long
// hold-off that backs the block up. A scoreboard keeps its own copy of the
// presence masks, stored addresses, prefix flags and node total. It predicts
// every response beat and compares each field in order of arrival.
// ----------------------------------------------------------------------------
module tb_decimal_key_index_table;
   import dkit_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_SPACE    = RADIX_DEF ** KEY_DIGITS_DEF;
   localparam int GROUPS       = KEY_SPACE / RADIX_DEF;
   localparam int PREFIX_SLOTS = (RADIX_DEF * (GROUPS - 1)) / (RADIX_DEF - 1);
   localparam int KEY_MAX      = (1 << KEY_W) - 1;

   localparam int RANDOM_ITEMS = 1850;
   localparam int HOT_GROUPS   = 12;
   localparam int RECENT_DEPTH = 64;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int REPORT_MAX   = 10;

   class index_scoreboard;
      bit [RADIX_DEF-1:0] present_mask [GROUPS];
      bit [ADDR_W-1:0]    stored_addr [KEY_SPACE];
      bit                 prefix_hit [PREFIX_SLOTS];
      int unsigned        node_total;
      rsp_type            pending [$];
      int unsigned        mismatches;

      function new();
         foreach (present_mask[i]) present_mask[i] = '0;
         foreach (prefix_hit[i]) prefix_hit[i] = 1'b0;
         node_total = 1;
         mismatches = 0;
      endfunction

      function void note_request(input req_type item);
         int unsigned k;
         int unsigned grp;
         int unsigned dig;
         int unsigned divisor;
         int unsigned offset;
         int unsigned span;
         int unsigned idx;
         int unsigned rank_val;
         rsp_type     exp_beat;
         k   = int'(item.key) % KEY_SPACE;
         grp = k / RADIX_DEF;
         dig = k % RADIX_DEF;
         if (item.cmd == CMD_INSERT) begin
            divisor = KEY_SPACE;
            offset  = 0;
            span    = 1;
            for (int l = 1; l < KEY_DIGITS_DEF; l++) begin
               divisor = divisor / RADIX_DEF;
               idx     = offset + k / divisor;
               if (idx < PREFIX_SLOTS && !prefix_hit[idx]) begin
                  prefix_hit[idx] = 1'b1;
                  if (node_total < NODE_MAX) node_total++;
               end
               span   = span * RADIX_DEF;
               offset = offset + span;
            end
            present_mask[grp][dig] = 1'b1;
            stored_addr[k] = item.record_addr;
         end
         exp_beat = '0;
         exp_beat.found = present_mask[grp][dig];
         if (exp_beat.found) begin
            rank_val = 1 + $countones(int'(present_mask[grp]) & ((1 << dig) - 1));
            if (rank_val > RANK_MAX) rank_val = RANK_MAX;
            exp_beat.rank     = RANK_W'(rank_val);
            exp_beat.addr_out = stored_addr[k];
         end
         exp_beat.node_count = NODE_W'(node_total);
         pending.push_back(exp_beat);
      endfunction

      function void check_response(input rsp_type got);
         rsp_type exp_beat;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response beat: found=%0d rank=%0d addr=%h nodes=%0d",
                        got.found, got.rank, got.addr_out, got.node_count);
            return;
         end
         exp_beat = pending.pop_front();
         if (got.found !== exp_beat.found || got.rank !== exp_beat.rank ||
             got.addr_out !== exp_beat.addr_out || got.node_count !== exp_beat.node_count) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("mismatch: exp found=%0d rank=%0d addr=%h nodes=%0d, got found=%0d rank=%0d addr=%h nodes=%0d",
                        exp_beat.found, exp_beat.rank, exp_beat.addr_out, exp_beat.node_count,
                        got.found, got.rank, got.addr_out, got.node_count);
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   index_scoreboard sb = new();

   int unsigned hot_group [HOT_GROUPS];
   int unsigned recent_keys [$];

   decimal_key_index_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: shifting stall pattern, one long hold-off part way through
   int unsigned     rsp_seen    = 0;
   int unsigned     hold_left   = 0;
   bit              hold_done   = 1'b0;
   bit [15:0]       ready_pattern = 16'hFFFF;
   int unsigned     pattern_age = 0;

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         sb.check_response(rsp_data);
         rsp_seen++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         pattern_age++;
         if (pattern_age >= 64) begin
            pattern_age = 0;
            ready_pattern = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom());
         end
         rsp_ready <= ready_pattern[pattern_age % 16];
      end
   end

   function automatic req_type make_req(input logic cmd, input int unsigned key,
                                        input logic [ADDR_W-1:0] addr);
      req_type item;
      item.cmd         = cmd;
      item.key         = KEY_W'(key);
      item.record_addr = addr;
      return item;
   endfunction

   function automatic req_type random_item();
      int unsigned     pick;
      int unsigned     k;
      logic [ADDR_W-1:0] addr;
      logic            cmd;
      pick = $urandom_range(99);
      if (pick < 60)
         k = hot_group[$urandom_range(HOT_GROUPS-1)] * RADIX_DEF + $urandom_range(RADIX_DEF-1);
      else if (pick < 75 && recent_keys.size() > 0)
         k = recent_keys[$urandom_range(recent_keys.size()-1)];
      else
         k = $urandom_range(KEY_MAX);
      if (k + KEY_SPACE <= KEY_MAX && $urandom_range(9) == 0) k = k + KEY_SPACE;
      cmd = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_LOOKUP;
      case ($urandom_range(15))
         0:       addr = '0;
         1:       addr = '1;
         default: addr = $urandom();
      endcase
      if (cmd == CMD_INSERT) begin
         recent_keys.push_back(k % KEY_SPACE);
         if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
      end
      return make_req(cmd, k, addr);
   endfunction

   task automatic send_beat(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   task automatic idle_gap(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      foreach (hot_group[i]) hot_group[i] = $urandom_range(GROUPS-1);
      hot_group[0] = 0;
      hot_group[1] = GROUPS - 1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed beats: empty table, extremes, wrapping keys, ranks, overwrite
      send_beat(make_req(CMD_LOOKUP, 0, '1));
      send_beat(make_req(CMD_INSERT, 0, '0));
      send_beat(make_req(CMD_LOOKUP, 0, '0));
      send_beat(make_req(CMD_INSERT, KEY_SPACE - 1, '1));
      send_beat(make_req(CMD_LOOKUP, KEY_SPACE - 1, '0));
      send_beat(make_req(CMD_LOOKUP, KEY_SPACE - RADIX_DEF, '0));
      send_beat(make_req(CMD_INSERT, KEY_MAX, 32'h3132_3334));
      send_beat(make_req(CMD_LOOKUP, KEY_MAX % KEY_SPACE, '0));
      send_beat(make_req(CMD_LOOKUP, KEY_MAX, '0));
      send_beat(make_req(CMD_INSERT, 5679, 32'hA5A5_5A5A));
      send_beat(make_req(CMD_INSERT, 5670, 32'h0000_0001));
      send_beat(make_req(CMD_INSERT, 5675, 32'h8000_0000));
      send_beat(make_req(CMD_LOOKUP, 5679, '0));
      send_beat(make_req(CMD_LOOKUP, 5675, '0));
      send_beat(make_req(CMD_INSERT, 5679, 32'h5A5A_A5A5));
      send_beat(make_req(CMD_LOOKUP, 5679, '0));
      send_beat(make_req(CMD_LOOKUP, 5674, '0));
      send_beat(make_req(CMD_INSERT, KEY_SPACE, 32'h3030_3030));
      send_beat(make_req(CMD_LOOKUP, 0, '0));
      send_beat(make_req(CMD_INSERT, 1234, 32'hDEAD_BEEF));
      send_beat(make_req(CMD_LOOKUP, KEY_SPACE + 1234, '0));
      send_beat(make_req(CMD_LOOKUP, KEY_SPACE - 1, '1));

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            if (sent % 150 == 149) hot_group[$urandom_range(HOT_GROUPS-1)] = $urandom_range(GROUPS-1);
            send_beat(random_item());
            sent++;
         end
         gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 60);
         if (gap > 0) idle_gap(gap);
      end
      idle_gap(0);

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.pending.size() != 0) begin
         $display("%0d response beats never arrived", sb.pending.size());
         sb.mismatches += sb.pending.size();
      end
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
